// ===== src/gsbm_pkg.sv =====
// Shared constants, mode codes and the command type of the sparse GF(2) block multiplier.
package gsbm_pkg;

	localparam int unsigned WINDOW_WORDS_DEF = 4096;
	localparam int unsigned IDX_W            = 12;
	localparam int unsigned DATA_W           = 64;
	localparam int unsigned MODE_W           = 3;

	localparam logic [MODE_W-1:0] MODE_WRITE_X = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE_B = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SPARSE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RUN     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

	// row and col hold window offsets already reduced; row_raw is the index as given
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  row_raw;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] data;
		logic              last;
	} cmd_t;

endpackage

// ===== src/gf2_sparse_block_matvec_top.sv =====
// Top level of the sparse GF(2) block matrix-vector multiplier.
// A read passes the front register, the queue, the back-end command register, the fetch
// registers and the result register. The back end takes no new transaction until the last
// leaves execute; each does one read-modify-write on the single-port x and b stores.
// Reset: arst_n clears handshake state, the queue and the row accumulator; x and b stores are
// not cleared and read as undefined until written.
module gf2_sparse_block_matvec_top import gsbm_pkg::*; #(
	parameter int unsigned WINDOW_WORDS = WINDOW_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [IDX_W-1:0]  row_index,
	input  logic [IDX_W-1:0]  col_index,
	input  logic [DATA_W-1:0] data_word,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] word,
	output logic [IDX_W-1:0]  index
);

	// front to queue
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	// queue to back
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// Classify the transaction, drop unused modes, fold indices into the window
	gsbm_front #(
		.WINDOW_WORDS(WINDOW_WORDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.row_index (row_index),
		.col_index (col_index),
		.data_word (data_word),
		.last      (last),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	// Decouple front and back so that each stalls on its own
	gsbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// Carry out writes, XOR updates and reads against the stores
	gsbm_back #(
		.WINDOW_WORDS(WINDOW_WORDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd  (pop_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.word     (word),
		.index    (index)
	);

endmodule

// ===== src/gsbm_front.sv =====
// Front end: accepts transactions, drops unused modes and folds indices into the window.
module gsbm_front import gsbm_pkg::*; #(
	parameter int unsigned WINDOW_WORDS = WINDOW_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [IDX_W-1:0]  row_index,
	input  logic [IDX_W-1:0]  col_index,
	input  logic [DATA_W-1:0] data_word,
	input  logic              last,
	output logic              push_valid,
	input  logic              push_ready,
	output cmd_t              push_cmd
);

	localparam bit          REDUCE  = (WINDOW_WORDS < 4096);
	localparam int unsigned RECIP   = (32'd1 << 24) / WINDOW_WORDS;
	localparam logic [20:0] RECIP_C = 21'(RECIP);
	localparam logic [16:0] WIN_C   = 17'(WINDOW_WORDS);

	logic        full_q;
	cmd_t        item_q;
	logic [8:0]  rq_q;
	logic [8:0]  cq_q;
	logic [32:0] row_prod;
	logic [32:0] col_prod;
	logic        accept;
	logic        mode_ok;
	logic        done;

	// remainder from a quotient estimate that is exact or one short
	function automatic logic [IDX_W-1:0] reduce_idx(input logic [IDX_W-1:0] idx,
			input logic [8:0] q);
		logic [25:0]      qw;
		logic [IDX_W-1:0] r;
		qw = {17'b0, q} * {9'b0, WIN_C};
		r  = idx - qw[IDX_W-1:0];
		if ({5'b0, r} >= WIN_C) begin
			r = r - WIN_C[IDX_W-1:0];
		end
		if (!REDUCE) begin
			r = idx;
		end
		return r;
	endfunction

	assign row_prod = {21'b0, row_index} * {12'b0, RECIP_C};
	assign col_prod = {21'b0, col_index} * {12'b0, RECIP_C};

	assign mode_ok    = (item_q.mode <= MODE_READ);
	assign push_valid = full_q && mode_ok;
	assign done       = full_q && (!mode_ok || push_ready);
	assign in_ready   = !full_q || done;
	assign accept     = in_valid && in_ready;

	always_comb begin
		push_cmd     = item_q;
		push_cmd.row = reduce_idx(item_q.row_raw, rq_q);
		push_cmd.col = reduce_idx(item_q.col, cq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (accept) begin
			full_q <= 1'b1;
		end else if (done) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.mode    <= mode;
			item_q.row_raw <= row_index;
			item_q.row     <= row_index;
			item_q.col     <= col_index;
			item_q.data    <= data_word;
			item_q.last    <= last;
			rq_q           <= row_prod[32:24];
			cq_q           <= col_prod[32:24];
		end
	end

endmodule

// ===== src/gsbm_queue.sv =====
// Two-entry command queue between the front end and the execution back end.
module gsbm_queue import gsbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/gsbm_back.sv =====
// Back end: x and b stores, row accumulator, read-modify-write sequencer and result register.
module gsbm_back import gsbm_pkg::*; #(
	parameter int unsigned WINDOW_WORDS = WINDOW_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  cmd_t              pop_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] word,
	output logic [IDX_W-1:0]  index
);

	localparam int unsigned AW = $clog2(WINDOW_WORDS);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_EXEC  = 3'b100
	} back_state_t;

	back_state_t       state_q;
	back_state_t       state_d;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] x_mem [WINDOW_WORDS];
	logic [DATA_W-1:0] b_mem [WINDOW_WORDS];
	logic [DATA_W-1:0] x_rd_s1;
	logic [DATA_W-1:0] b_rd_s1;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] word_q;
	logic [IDX_W-1:0]  index_q;
	logic              out_valid_q;
	logic [AW-1:0]     row_a;
	logic [AW-1:0]     col_a;
	logic              is_exec;
	logic              is_read;
	logic              finish;
	logic              pop;

	assign row_a   = AW'(cmd_q.row);
	assign col_a   = AW'(cmd_q.col);
	assign is_exec = (state_q == ST_EXEC);
	assign is_read = (cmd_q.mode == MODE_READ);
	// a read holds in execute until the result register is free
	assign finish    = is_exec && (!is_read || !out_valid_q || out_ready);
	assign pop_ready = (state_q == ST_IDLE) || finish;
	assign pop       = pop_valid && pop_ready;

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign index     = index_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (pop) begin
					state_d = ST_FETCH;
				end else if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (is_exec && cmd_q.mode == MODE_RUN) begin
				acc_q <= cmd_q.last ? '0 : (acc_q ^ x_rd_s1);
			end
			if (finish && is_read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
		end
		if (state_q == ST_FETCH) begin
			x_rd_s1 <= x_mem[col_a];
			b_rd_s1 <= b_mem[row_a];
		end
		if (finish && is_read) begin
			word_q  <= b_rd_s1;
			index_q <= cmd_q.row_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (is_exec) begin
			case (cmd_q.mode)
				MODE_WRITE_X: begin
					x_mem[col_a] <= cmd_q.data;
				end
				MODE_WRITE_B: begin
					b_mem[row_a] <= cmd_q.data;
				end
				MODE_SPARSE: begin
					b_mem[row_a] <= b_rd_s1 ^ x_rd_s1;
				end
				MODE_RUN: begin
					if (cmd_q.last) begin
						b_mem[row_a] <= b_rd_s1 ^ acc_q ^ x_rd_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
